[rtl/core/lcfr_pkg.sv]
// ----------------------------------------------------------------------------
// lcfr_pkg
// Shared types and constants for the length/checksum frame receiver.
// ----------------------------------------------------------------------------
package lcfr_pkg;

    localparam logic [7:0] HdrByte     = 8'h10;
    localparam logic [7:0] TypeMask    = 8'h80;
    localparam logic [7:0] CtrlMask    = 8'hC0;
    localparam logic [7:0] CtrlUnnum   = 8'hC0;
    localparam logic [7:0] PollSetByte = 8'hC8;
    localparam logic [7:0] NoPollByte  = 8'hC0;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_SUM    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CLS_INFO  = 2'd0,
        CLS_SUPER = 2'd1,
        CLS_UNNUM = 2'd2,
        CLS_EMPTY = 2'd3
    } frame_class_t;

    typedef struct packed {
        logic         frame_status;
        frame_class_t frame_class;
        logic [7:0]   control_byte;
        logic [15:0]  data_length;
        logic [7:0]   checksum_received;
        logic [7:0]   checksum_computed;
        logic         reply_request;
        logic         bad_unnumbered;
        logic [7:0]   reply_byte;
    } result_t;

    function automatic frame_class_t classify(input logic [15:0] len, input logic [7:0] ctrl);
        frame_class_t cls;
        if (len == 16'd0)
            cls = CLS_EMPTY;
        else if ((ctrl & TypeMask) == 8'd0)
            cls = CLS_INFO;
        else if ((ctrl & CtrlMask) == CtrlUnnum)
            cls = CLS_UNNUM;
        else
            cls = CLS_SUPER;
        return cls;
    endfunction

endpackage

[rtl/core/lcfr_parser.sv]
// ----------------------------------------------------------------------------
// lcfr_parser
// Frame parse state machine with running checksum; one byte per step.
// ----------------------------------------------------------------------------
module lcfr_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              result_hit,
    output lcfr_pkg::result_t result
);

    lcfr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  first_reg, first_next;

    lcfr_pkg::frame_class_t cls;
    logic good;
    logic unnum_good;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lcfr_pkg::PH_HUNT;
            length_reg    <= '0;
            remaining_reg <= '0;
            sum_reg       <= '0;
            first_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            first_reg     <= first_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        first_next     = first_reg;
        result_hit     = 1'b0;
        unique case (phase_reg)
            lcfr_pkg::PH_LEN_HI:
            begin
                length_next = {rx_byte, 8'd0};
                phase_next  = lcfr_pkg::PH_LEN_LO;
            end
            lcfr_pkg::PH_LEN_LO:
            begin
                length_next    = {length_reg[15:8], rx_byte};
                remaining_next = {length_reg[15:8], rx_byte};
                sum_next       = '0;
                first_next     = '0;
                phase_next     = ({length_reg[15:8], rx_byte} != 16'd0) ?
                                 lcfr_pkg::PH_DATA : lcfr_pkg::PH_SUM;
            end
            lcfr_pkg::PH_DATA:
            begin
                if (remaining_reg == length_reg)
                    first_next = rx_byte;
                sum_next       = sum_reg + rx_byte;
                remaining_next = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                    phase_next = lcfr_pkg::PH_SUM;
            end
            lcfr_pkg::PH_SUM:
            begin
                result_hit = 1'b1;
                phase_next = lcfr_pkg::PH_HUNT;
            end
            default:
            begin
                // unused codes hunt as well
                phase_next = (rx_byte == lcfr_pkg::HdrByte) ?
                             lcfr_pkg::PH_LEN_HI : lcfr_pkg::PH_HUNT;
            end
        endcase
    end

    assign good       = (rx_byte == sum_reg);
    assign cls        = lcfr_pkg::classify(length_reg, first_reg);
    assign unnum_good = good && (cls == lcfr_pkg::CLS_UNNUM);

    always_comb
    begin
        result.frame_status      = !good;
        result.frame_class       = cls;
        result.control_byte      = first_reg;
        result.data_length       = length_reg;
        result.checksum_received = rx_byte;
        result.checksum_computed = sum_reg;
        result.reply_request     = unnum_good && (first_reg == lcfr_pkg::PollSetByte);
        result.bad_unnumbered    = unnum_good && (first_reg != lcfr_pkg::PollSetByte);
        result.reply_byte        = (unnum_good && (first_reg == lcfr_pkg::PollSetByte)) ?
                                   lcfr_pkg::NoPollByte : 8'd0;
    end

endmodule

[rtl/core/length_checksum_frame_receiver.sv]
// ----------------------------------------------------------------------------
// length_checksum_frame_receiver
// Length-prefixed frame receiver with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Input channel: byte_valid/byte_stall carry rx_byte, one serial byte per
// transaction. Bytes outside a frame (before header 0x10) are dropped.
// Output channel: result_valid/result_stall carry one result per frame,
// presented after the trailing checksum byte.
// Throughput: one byte per cycle unless a stalled result holds a checksum byte.
// Every byte lands in an input register, the parse step runs between
// that register and the result register. An accepted checksum byte lands
// in the input register; the result register loads when that byte moves
// on, which a waiting stalled result can hold off.
// Stall: while a result waits, bytes that produce no result keep flowing;
// the next checksum byte is held in the input register and byte_stall
// rises until the waiting result is taken.
// Reset: rst_n clears the parser to header hunt and empties both registers.
// ----------------------------------------------------------------------------
module length_checksum_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        frame_status,
    output logic [1:0]  frame_class,
    output logic [7:0]  control_byte,
    output logic [15:0] data_length,
    output logic [7:0]  checksum_received,
    output logic [7:0]  checksum_computed,
    output logic        reply_request,
    output logic        bad_unnumbered,
    output logic [7:0]  reply_byte
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    lcfr_pkg::result_t out_reg;

    logic              hit;
    lcfr_pkg::result_t result;
    logic              fire;
    logic              accept;

    lcfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .rx_byte (in_byte_reg),
        .result_hit (hit),
        .result  (result)
    );

    // a held byte moves on unless it makes a result and the result slot is blocked
    assign fire       = in_valid_reg && (!hit || !out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_valid_next = accept || (in_valid_reg && !fire);
        if (fire && hit)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= rx_byte;
        if (fire && hit)
            out_reg <= result;
    end

    assign result_valid      = out_valid_reg;
    assign frame_status      = out_reg.frame_status;
    assign frame_class       = out_reg.frame_class;
    assign control_byte      = out_reg.control_byte;
    assign data_length       = out_reg.data_length;
    assign checksum_received = out_reg.checksum_received;
    assign checksum_computed = out_reg.checksum_computed;
    assign reply_request     = out_reg.reply_request;
    assign bad_unnumbered    = out_reg.bad_unnumbered;
    assign reply_byte        = out_reg.reply_byte;

endmodule

[rtl/core/lcfr_checker.sv]
// ----------------------------------------------------------------------------
// lcfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module lcfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic        frame_status,
    input logic [1:0]  frame_class,
    input logic [7:0]  control_byte,
    input logic [15:0] data_length,
    input logic [7:0]  checksum_computed,
    input logic        reply_request,
    input logic        bad_unnumbered,
    input logic [7:0]  reply_byte
);

    // a stalled result transaction stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_reply_only_good_unnum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reply_request |->
            !frame_status && frame_class == lcfr_pkg::CLS_UNNUM &&
            control_byte == lcfr_pkg::PollSetByte && !bad_unnumbered &&
            reply_byte == lcfr_pkg::NoPollByte)
        else $error("reply request on a frame that does not call for one");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_class == lcfr_pkg::CLS_EMPTY |->
            data_length == 16'd0 && control_byte == 8'd0 && checksum_computed == 8'd0)
        else $error("empty frame reports data");

    a_bad_no_route: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_status |->
            !reply_request && !bad_unnumbered && reply_byte == 8'd0)
        else $error("frame with bad checksum was routed");

endmodule

bind length_checksum_frame_receiver lcfr_checker u_lcfr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .frame_status      (frame_status),
    .frame_class       (frame_class),
    .control_byte      (control_byte),
    .data_length       (data_length),
    .checksum_computed (checksum_computed),
    .reply_request     (reply_request),
    .bad_unnumbered    (bad_unnumbered),
    .reply_byte        (reply_byte)
);
